FILE: rtl/lckm_pkg.sv
package lckm_pkg;

    localparam int LINE_MAX_DEF      = 64;
    localparam int NUM_KEYWORDS_DEF  = 15;
    localparam int HINT_POSITION_DEF = 4;

    // The keyword table has room for 32 entries of 16 characters.
    localparam int KW_SLOTS  = 32;
    localparam int KW_WIDTH  = 16;
    localparam int KW_IDX_W  = $clog2(KW_SLOTS);
    localparam int BYTE_W    = 8;
    localparam int CMD_IDX_W = 4;
    localparam int LEN_W     = 6;
    localparam int OUTC_W    = 2;

    localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;

    typedef enum logic [OUTC_W-1:0] {
        OUTC_UNDECIDED = 2'd0,
        OUTC_MATCHED   = 2'd1,
        OUTC_UNKNOWN   = 2'd2,
        OUTC_HINT      = 2'd3
    } t_outcome;

    typedef struct packed {
        logic                none_left;
        logic                one_left;
        logic [KW_IDX_W-1:0] match_idx;
        logic [KW_IDX_W-1:0] hint_idx;
    } t_match_res;

    // Each row is left-aligned: character 0 sits in the top byte, zero padded.
    function automatic logic [8*KW_WIDTH-1:0] kw_row(input logic [KW_IDX_W-1:0] k);
        logic [8*KW_WIDTH-1:0] row;
        row = '0;
        unique case (k)
            5'd0:    row = {"BAT",            104'h0};
            5'd1:    row = {"CLK",            104'h0};
            5'd2:    row = {"LIN VALUES",      48'h0};
            5'd3:    row = {"LIN THRESHOLDS",  16'h0};
            5'd4:    row = {"LIN WHITES",      48'h0};
            5'd5:    row = {"LIN BLACKS",      48'h0};
            5'd6:    row = {"GET",            104'h0};
            5'd7:    row = {"SET",            104'h0};
            5'd8:    row = {"VER",            104'h0};
            5'd9:    row = {"STREAM_", "BAT",    48'h0};
            5'd10:   row = {"STREAM_", "BUZ",    48'h0};
            5'd11:   row = {"STREAM_", "LED",    48'h0};
            5'd12:   row = {"STREAM_", "LINE",   40'h0};
            5'd13:   row = {"STREAM_", "MOTORS", 24'h0};
            5'd14:   row = {"MAP ALL",         72'h0};
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic logic [BYTE_W-1:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                                  input logic [3:0]          pos,
                                                  input logic                past_end);
        logic [8*KW_WIDTH-1:0] row;
        logic [BYTE_W-1:0]     ch;
        row = kw_row(k);
        ch  = row[8*(KW_WIDTH-1-int'(pos)) +: 8];
        return past_end ? '0 : ch;
    endfunction

endpackage

FILE: rtl/lckm_in_if.sv
interface lckm_in_if;
    import lckm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/lckm_out_if.sv
interface lckm_out_if;
    import lckm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUTC_W-1:0]    outcome;
    logic [CMD_IDX_W-1:0] command_index;
    logic [LEN_W-1:0]     line_length;

    modport source (output valid, output outcome, output command_index,
                    output line_length, input ready);
    modport sink   (input valid, input outcome, input command_index,
                    input line_length, output ready);
endinterface

FILE: rtl/lckm_match.sv
module lckm_match
    import lckm_pkg::*;
#(
    parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF,
    parameter int POS_W        = $clog2(LINE_MAX_DEF)
) (
    input  logic [BYTE_W-1:0]       i_byte,
    input  logic [POS_W-1:0]        i_pos,
    input  logic [NUM_KEYWORDS-1:0] i_mask,
    output logic [NUM_KEYWORDS-1:0] o_mask,
    output t_match_res              o_res
);

    localparam int PX_W = POS_W + 5;

    logic [PX_W-1:0]         pos_ext;
    logic                    past_end;
    logic [NUM_KEYWORDS-1:0] differ;

    assign pos_ext  = {5'd0, i_pos};
    assign past_end = (pos_ext >= PX_W'(KW_WIDTH));

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            differ[k] = (kw_char(KW_IDX_W'(k), pos_ext[3:0], past_end) != i_byte);
        end
    end

    assign o_mask = i_mask & ~differ;

    always_comb begin
        o_res.none_left = (o_mask == '0);
        o_res.one_left  = $onehot(o_mask);
        // Lowest survivor; only meaningful when a single one is left.
        o_res.match_idx = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (o_mask[k]) begin
                o_res.match_idx = KW_IDX_W'(k);
            end
        end
        // When every candidate goes at once, the last one dropped is the
        // highest-index candidate that was still live.
        o_res.hint_idx = '0;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (i_mask[k]) begin
                o_res.hint_idx = KW_IDX_W'(k);
            end
        end
    end

endmodule

FILE: rtl/line_command_keyword_matcher_unit.sv
// Channel   Direction  Payload                                     Transfer when
// i_rx      in         rx_byte[7:0]                                valid && ready
// o_res     out        outcome[1:0] command_index[3:0] line_length valid && ready
//
// Each byte is matched against all keywords while it sits in the input register,
// and line state updates at the next edge: one byte per cycle unless o_res stalls.
// A CR or LF after two or more characters loads its result into the output register.
// Reset clears the line state and the valid flags of both registers.
// While a result waits on o_res the input register still takes one byte.
module line_command_keyword_matcher_unit
    import lckm_pkg::*;
#(
    parameter int LINE_MAX      = LINE_MAX_DEF,
    parameter int NUM_KEYWORDS  = NUM_KEYWORDS_DEF,
    parameter int HINT_POSITION = HINT_POSITION_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lckm_in_if.sink       i_rx,
    lckm_out_if.source    o_res
);

    localparam int POS_W = $clog2(LINE_MAX);
    localparam int PX_W  = POS_W + LEN_W;

    logic                    r_in_valid;
    logic [BYTE_W-1:0]       r_in_byte;

    logic [NUM_KEYWORDS-1:0] r_mask;
    logic [POS_W-1:0]        r_pos;
    t_outcome                r_latched;
    logic [KW_IDX_W-1:0]     r_idx;

    logic                    r_out_valid;
    t_outcome                r_out_outcome;
    logic [CMD_IDX_W-1:0]    r_out_idx;
    logic [LEN_W-1:0]        r_out_len;

    logic [NUM_KEYWORDS-1:0] match_mask;
    t_match_res              match_res;
    logic                    advance;
    logic                    is_eol;
    logic                    emit;
    logic [PX_W-1:0]         pos_ext;

    assign advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign is_eol  = (r_in_byte == CHAR_LF) || (r_in_byte == CHAR_CR);
    assign pos_ext = {{LEN_W{1'b0}}, r_pos};
    assign emit    = advance && is_eol && (pos_ext > PX_W'(1));

    assign i_rx.ready = !r_in_valid || advance;

    lckm_match #(
        .NUM_KEYWORDS (NUM_KEYWORDS),
        .POS_W        (POS_W)
    ) u_match (
        .i_byte (r_in_byte),
        .i_pos  (r_pos),
        .i_mask (r_mask),
        .o_mask (match_mask),
        .o_res  (match_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Line state: the end of a line or a full line buffer starts a new line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '1;
            r_pos     <= '0;
            r_latched <= OUTC_UNDECIDED;
            r_idx     <= '0;
        end else if (advance) begin
            if (is_eol || (r_pos == POS_W'(LINE_MAX - 1))) begin
                r_mask    <= '1;
                r_pos     <= '0;
                r_latched <= OUTC_UNDECIDED;
                r_idx     <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
                if (r_latched == OUTC_UNDECIDED) begin
                    r_mask <= match_mask;
                    priority if (match_res.one_left) begin
                        r_latched <= OUTC_MATCHED;
                        r_idx     <= match_res.match_idx;
                    end else if (match_res.none_left) begin
                        if (pos_ext < PX_W'(HINT_POSITION)) begin
                            r_latched <= OUTC_UNKNOWN;
                            r_idx     <= '0;
                        end else begin
                            r_latched <= OUTC_HINT;
                            r_idx     <= match_res.hint_idx;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_outcome <= r_latched;
            r_out_idx     <= r_idx[CMD_IDX_W-1:0];
            r_out_len     <= pos_ext[LEN_W-1:0];
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.outcome       = r_out_outcome;
    assign o_res.command_index = r_out_idx;
    assign o_res.line_length   = r_out_len;

    a_matched_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched == OUTC_MATCHED |-> $onehot(r_mask))
        else $error("matched outcome without a single live keyword");

    a_undecided_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched == OUTC_UNDECIDED |-> r_mask != '0)
        else $error("undecided line with no live keyword");

    a_unknown_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched == OUTC_UNKNOWN |-> r_idx == '0)
        else $error("unknown outcome carries an index");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_pos == '0 && r_latched == OUTC_UNDECIDED)
        else $error("line state not cleared after a result");

    a_reset_pos: assert property (@(posedge i_clk)
        !i_rst_n |=> r_pos == '0 && !r_out_valid)
        else $error("reset did not clear the line");

endmodule
